// ----- src/sha_pkg.sv -----
// shared types, constants and round functions for the sha-256 stream hasher
// no dependencies
package sha_pkg;

  localparam int BlockBytes = 64;
  localparam int LenOffset  = 56;
  localparam logic [7:0] PadMark = 8'h80;
  localparam int QDepth = 4;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } st_t;

  function automatic word_t round_k(input logic [5:0] i);
    word_t k [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    return k[i];
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };
    return h[i];
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- src/sha_queue.sv -----
// short item queue between the front and the back
// depends on sha_pkg
module sha_queue import sha_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  input  item_t wr_item,
  output logic  full,
  input  logic  rd_take,
  output logic  rd_valid,
  output item_t rd_item
);
  localparam int AW = $clog2(QDepth);

  item_t           mem [QDepth];
  logic [AW-1:0]   wp;
  logic [AW-1:0]   rp;
  logic [AW:0]     cnt;

  assign full     = (cnt == (AW+1)'(QDepth));
  assign rd_valid = (cnt != '0);
  assign rd_item  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && !full) begin
      mem[wp] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr_valid && !full) wp <= wp + 1'b1;
      if (rd_take && rd_valid) rp <= rp + 1'b1;
      cnt <= cnt + (AW+1)'(wr_valid && !full) - (AW+1)'(rd_take && rd_valid);
    end
  end
endmodule

// ----- src/sha_back.sv -----
// block buffer, padding sequencer, 64-round compression and digest output
// depends on sha_pkg
module sha_back import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_take,
  output logic [31:0] digest_word,
  output logic        last_word,
  output logic        valid,
  input  logic        stall
);
  st_t         state, state_next;
  logic [6:0]  fill;
  logic [63:0] bit_len;
  word_t       hw [8];
  word_t       v  [8];
  word_t       w  [16];
  logic [5:0]  rnd;
  logic        pend_end;
  logic        final_blk;
  logic        in_pad;
  logic [2:0]  emit_idx;

  // pad write for current fill position
  logic [7:0]  pad_byte;
  logic [5:0]  fpos;
  assign fpos = fill[5:0];

  always_comb begin
    pad_byte = 8'h00;
    if (pend_end) begin
      pad_byte = PadMark;
    end else if (final_blk && fill >= 7'(LenOffset)) begin
      pad_byte = bit_len[{~fpos[2:0], 3'b000} +: 8];
    end
  end

  // round logic
  word_t s0, s1, wn, t1, t2, ch, mj, b0, b1;
  always_comb begin
    s0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wn = s1 + w[9] + s0 + w[0];
    b1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + b1 + ch + round_k(rnd) + w[0];
    b0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = b0 + mj;
  end

  always_comb begin
    state_next = state;
    q_take     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_take = 1'b1;
          if (q_item.present && fill == 7'd63) state_next = ST_COMP;
          else if (q_item.last) state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (fill == 7'(BlockBytes-1)) state_next = ST_COMP;
      end
      ST_COMP: begin
        if (rnd == 6'd63) state_next = ST_FOLD;
      end
      ST_FOLD: begin
        if (final_blk) state_next = ST_EMIT;
        else if (pend_end || in_pad) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_EMIT: begin
        if (!stall && emit_idx == 3'd7) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign valid       = (state == ST_EMIT);
  assign digest_word = hw[emit_idx];
  assign last_word   = (emit_idx == 3'd7);

  // the schedule registers double as the block buffer between compressions
  always_ff @(posedge clk) begin
    if (state == ST_COMP) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
      v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
    end else begin
      for (int i = 0; i < 8; i++) v[i] <= hw[i];
      if (state == ST_IDLE && q_valid && q_item.present) begin
        w[fpos[5:2]][{~fpos[1:0], 3'b000} +: 8] <= q_item.data;
      end else if (state == ST_PAD) begin
        w[fpos[5:2]][{~fpos[1:0], 3'b000} +: 8] <= pad_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      bit_len   <= '0;
      rnd       <= '0;
      pend_end  <= 1'b0;
      final_blk <= 1'b0;
      in_pad    <= 1'b0;
      emit_idx  <= '0;
      for (int i = 0; i < 8; i++) hw[i] <= init_hash(3'(i));
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            pend_end  <= q_item.last;
            final_blk <= 1'b0;
            rnd       <= '0;
            if (q_item.present) begin
              fill    <= (fill == 7'd63) ? 7'd0 : fill + 7'd1;
              bit_len <= bit_len + 64'd8;
            end
          end
        end
        ST_PAD: begin
          fill <= (fill == 7'(BlockBytes-1)) ? 7'd0 : fill + 7'd1;
          if (pend_end) begin
            // length fits behind the mark only below the length field
            pend_end  <= 1'b0;
            in_pad    <= 1'b1;
            final_blk <= (fpos < 6'(LenOffset));
          end
          if (fill == 7'(BlockBytes-1)) rnd <= '0;
        end
        ST_COMP: begin
          rnd <= rnd + 6'd1;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) hw[i] <= hw[i] + v[i];
          emit_idx <= '0;
          if (in_pad && !final_blk) final_blk <= 1'b1;
        end
        ST_EMIT: begin
          if (!stall) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              fill      <= '0;
              bit_len   <= '0;
              final_blk <= 1'b0;
              in_pad    <= 1'b0;
              for (int i = 0; i < 8; i++) hw[i] <= init_hash(3'(i));
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- src/sha256_stream_hasher_core.sv -----
// top level: input queue front and compression back of the sha-256 hasher
// depends on sha_pkg, sha_queue, sha_back
//
//  channel | signals                                                 | dir
//  in      | in_valid in_stall data_byte byte_present end_of_message | in
//  out     | out_valid out_stall digest_word last_word               | out
//
// a byte word is registered in the four-deep queue and then taken by the back while it is idle
// a full block holds the back for 64 rounds plus a fold of the hash
// the end of a message adds one pad write per slot left in the block and a
// compression; a mark at slot 56 or later adds 64 pad writes and another
// compression; then eight digest words; in_stall rises when the queue is
// full; rst clears control state and restores the initial hash values
// stall on the output holds the current digest word
module sha256_stream_hasher_core import sha_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic        last_word
);
  item_t in_item, q_item;
  logic  full, q_valid, q_take;

  assign in_item  = '{data: data_byte, present: byte_present, last: end_of_message};
  assign in_stall = full;

  sha_queue u_queue (
    .clk, .rst,
    .wr_valid(in_valid), .wr_item(in_item), .full,
    .rd_take(q_take), .rd_valid(q_valid), .rd_item(q_item)
  );

  sha_back u_back (
    .clk, .rst,
    .q_valid, .q_item, .q_take,
    .digest_word, .last_word,
    .valid(out_valid), .stall(out_stall)
  );
endmodule

// ----- tb/sv/tb_sha256_stream_hasher_core.sv -----
// testbench for sha256_stream_hasher_core: byte words in, digest words out
// depends on sha_pkg and the core; predicts digests with its own sha-256 model
`timescale 1ns / 1ps

module tb_sha256_stream_hasher_core;
  import sha_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       present;
    logic       last;
  } byte_word_t;

  typedef struct {
    logic [31:0] digest;
    logic        last;
  } digest_word_t;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam int LIMIT = 2000000;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [7:0]  data_byte = 0;
  logic        byte_present = 0;
  logic        end_of_message = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [31:0] digest_word;
  logic        last_word;

  sha256_stream_hasher_core dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  byte_word_t   pending_words[$];
  digest_word_t expected_digests[$];
  int  errors = 0;
  int  cycles = 0;
  bit  stim_done = 0;
  bit  drain_hold = 0;
  int  in_gap = 0;
  int  out_gap = 0;

  logic [31:0] hash_st [8];
  logic [7:0]  blk [64];
  int          fill;
  logic [63:0] bit_count;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  task automatic run_rounds();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    v = hash_st;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_st[i] += v[i];
  endtask

  task automatic predict_digest(byte_word_t it);
    digest_word_t d;
    if (it.present) begin
      blk[fill] = it.data;
      fill++;
      bit_count += 64'd8;
      if (fill == BlockBytes) begin
        run_rounds();
        fill = 0;
      end
    end
    if (!it.last) return;
    blk[fill] = PadMark;
    fill++;
    if (fill > LenOffset) begin
      while (fill < BlockBytes) blk[fill++] = 8'h00;
      run_rounds();
      fill = 0;
    end
    while (fill < LenOffset) blk[fill++] = 8'h00;
    for (int i = 0; i < 8; i++) blk[LenOffset + i] = bit_count[63 - 8*i -: 8];
    run_rounds();
    for (int i = 0; i < 8; i++) begin
      d.digest = hash_st[i];
      d.last = (i == 7);
      expected_digests.push_back(d);
    end
    hash_st = H_INIT;
    fill = 0;
    bit_count = '0;
  endtask

  task automatic add_word(logic [7:0] b, logic p, logic l);
    byte_word_t it;
    it.data = b; it.present = p; it.last = l;
    pending_words.push_back(it);
  endtask

  task automatic add_message(int len, bit eom_with_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) add_word(8'($urandom), 1'b0, 1'b0);
      add_word(8'($urandom), 1'b1, eom_with_byte && i == len - 1);
    end
    if (!eom_with_byte || len == 0) add_word(8'($urandom), 1'b0, 1'b1);
  endtask

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_digest('{data_byte, byte_present, end_of_message});
        in_gap = gap_len();
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0 || drain_hold || pending_words.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid <= 1'b0;
        end else begin
          byte_word_t it;
          it = pending_words.pop_front();
          in_valid <= 1'b1;
          data_byte <= it.data;
          byte_present <= it.present;
          end_of_message <= it.last;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        digest_word_t e;
        if (expected_digests.size() == 0) begin
          $error("unexpected digest word %h", digest_word);
          errors++;
        end else begin
          e = expected_digests.pop_front();
          if (digest_word !== e.digest) begin
            $error("digest_word expected %h actual %h", e.digest, digest_word);
            errors++;
          end
          if (last_word !== e.last) begin
            $error("last_word expected %b actual %b", e.last, last_word);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_gap = gap_len();
        out_stall <= (out_gap > 0);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("FAIL sha256_stream_hasher_core");
      $finish;
    end
  end

  initial begin
    int total;
    hash_st = H_INIT;
    fill = 0;
    bit_count = '0;
    foreach (blk[i]) blk[i] = 8'h00;
    add_word(8'h00, 1'b0, 1'b0);
    add_word(8'h00, 1'b0, 1'b1);
    add_word(8'h00, 1'b1, 1'b1);
    add_word(8'hff, 1'b1, 1'b1);
    add_word(8'h61, 1'b1, 1'b0);
    add_word(8'h62, 1'b1, 1'b0);
    add_word(8'h63, 1'b1, 1'b1);
    add_word(8'haa, 1'b0, 1'b0);
    add_word(8'h55, 1'b1, 1'b0);
    add_word(8'h00, 1'b0, 1'b1);
    repeat (7) @(posedge clk);
    rst <= 0;
    // padding boundaries: 55 fits, 56 spills, 64 ends on a full block
    add_message(55, 1);
    add_message(56, 0);
    add_message(64, 1);
    // sender pauses until every digest is out
    wait (pending_words.size() == 0);
    drain_hold = 1;
    wait (expected_digests.size() == 0 && !in_valid);
    repeat (20) @(posedge clk);
    drain_hold = 0;
    total = 0;
    while (total < 50) begin
      int len;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(56, 72) : $urandom_range(0, 12);
      add_message(len, 1'($urandom_range(0, 1)));
      total += len + 1;
    end
    wait (pending_words.size() == 0 && !in_valid);
    wait (expected_digests.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_digests.size() == 0) begin
      $display("PASS sha256_stream_hasher_core");
    end else begin
      $display("FAIL sha256_stream_hasher_core");
    end
    $finish;
  end
endmodule
